@@ hdl/i2c_eeprom_target_defines.svh @@
// Assertion helpers used by the top-level RTL.
`ifndef I2C_EEPROM_TARGET_DEFINES_SVH
`define I2C_EEPROM_TARGET_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and idle during reset.
`define I2CEE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle during reset.
`define I2CEE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/i2cee_pkg.sv @@
`timescale 1ns / 1ps

package i2cee_pkg;

  localparam int unsigned MemBytesDefault = 32768;
  localparam int unsigned CfgAddrW        = 5;
  localparam int unsigned CfgDataW        = 32;

  typedef enum logic [1:0] {
    FUNC_ADDR  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_DEV_ADDR    = 3'd0,
    REG_DEV_EN      = 3'd1,
    REG_ADDR_BYTES  = 3'd2,
    REG_PAGE_LOG2   = 3'd3,
    REG_MEM_SIZE    = 3'd4,
    REG_WPROT       = 3'd5,
    REG_WDELAY      = 3'd6
  } reg_e;

  // Where a write transaction stands.
  typedef enum logic [1:0] {
    POS_IDLE      = 2'd0,
    POS_ADDR_HI   = 2'd1,
    POS_DATA_NONE = 2'd2,
    POS_DATA_SEEN = 2'd3
  } pos_e;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic [7:0] write_data;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic        device_enabled;
    logic [1:0]  addr_len;
    logic [3:0]  page_size_log2;
    logic [15:0] mem_span;
    logic        wr_lock;
    logic [15:0] write_delay_ticks;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    device_address:    7'd80,
    device_enabled:    1'b1,
    addr_len:          2'd2,
    page_size_log2:    4'd6,
    mem_span:          16'd32768,
    wr_lock:           1'b0,
    write_delay_ticks: 16'd5
  };

endpackage

@@ hdl/i2cee_ram.sv @@
`timescale 1ns / 1ps

module i2cee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/i2cee_regs.sv @@
`timescale 1ns / 1ps

module i2cee_regs
  import i2cee_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign idx    = reg_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DEV_ADDR:   cfg_d.device_address    = pwdata[6:0];
        REG_DEV_EN:     cfg_d.device_enabled    = pwdata[0];
        REG_ADDR_BYTES: cfg_d.addr_len          = pwdata[1:0];
        REG_PAGE_LOG2:  cfg_d.page_size_log2    = pwdata[3:0];
        REG_MEM_SIZE:   cfg_d.mem_span          = pwdata[15:0];
        REG_WPROT:      cfg_d.wr_lock           = pwdata[0];
        REG_WDELAY:     cfg_d.write_delay_ticks = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEV_ADDR:   prdata = {25'd0, cfg_q.device_address};
      REG_DEV_EN:     prdata = {31'd0, cfg_q.device_enabled};
      REG_ADDR_BYTES: prdata = {30'd0, cfg_q.addr_len};
      REG_PAGE_LOG2:  prdata = {28'd0, cfg_q.page_size_log2};
      REG_MEM_SIZE:   prdata = {16'd0, cfg_q.mem_span};
      REG_WPROT:      prdata = {31'd0, cfg_q.wr_lock};
      REG_WDELAY:     prdata = {16'd0, cfg_q.write_delay_ticks};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/i2cee_core.sv @@
`timescale 1ns / 1ps

module i2cee_core
  import i2cee_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MemBytesDefault,
  localparam int unsigned AW = $clog2(MEM_BYTES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  item_t         in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          ack_o,
  output logic          read_valid_o,
  output logic          busy_res_o,
  output logic          clearing_o,
  output logic          ram_we_o,
  output logic          ram_re_o,
  output logic [AW-1:0] ram_addr_o,
  output logic [7:0]    ram_wdata_o
);

  localparam logic [16:0]   MemBytesW = 17'(MEM_BYTES);
  localparam logic [AW-1:0] LastAddr  = AW'(MEM_BYTES - 1);

  function automatic logic [7:0] page_mask(input logic [3:0] lg);
    logic [3:0] sat;
    logic [8:0] m;
    sat = (lg > 4'd8) ? 4'd8 : lg;
    m   = (9'd1 << sat) - 9'd1;
    return m[7:0];
  endfunction

  pos_e        pos_q, pos_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] busy_q, busy_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] pb_q, pb_d;
  logic [7:0]  bw_q, bw_d;
  logic        stop_q, stop_d;
  logic        clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic        out_valid_q, out_valid_d;
  logic        ack_q, ack_d, rvalid_q, rvalid_d, bres_q, bres_d;

  logic        accept;
  logic [15:0] limit;
  logic [7:0]  mask8;
  logic [1:0]  ab;
  logic [7:0]  b;

  // Write byte intermediates
  logic        begin_v, store_v;
  pos_e        pos_a, pos_s;
  logic [15:0] cur_a, pb_a;
  logic [7:0]  held_a, bw_a, bw_s, off;
  logic        stop_a, stop_s, can_store, in_range, do_wr;
  logic [15:0] eff, fin_addr;

  assign in_stall_o = clr_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign clearing_o = clr_q;

  assign limit = ({1'b0, cfg_i.mem_span} < MemBytesW) ? cfg_i.mem_span
                                                       : MemBytesW[15:0];
  assign mask8 = page_mask(cfg_i.page_size_log2);
  assign ab    = (cfg_i.addr_len == 2'd3) ? 2'd0 : cfg_i.addr_len;
  assign b     = in_data_i.write_data;

  // Leading address bytes and the start of the data phase.
  always_comb begin
    begin_v = 1'b0;
    store_v = 1'b0;
    cur_a   = cur_q;
    held_a  = held_q;
    pos_a   = pos_q;
    unique case (pos_q)
      POS_IDLE: begin
        if (ab == 2'd2) begin
          if (in_data_i.last_byte) begin
            begin_v = 1'b1;
            store_v = 1'b1;
          end else begin
            held_a = b;
            pos_a  = POS_ADDR_HI;
          end
        end else if (ab == 2'd1) begin
          cur_a   = {8'd0, b};
          begin_v = 1'b1;
        end else begin
          begin_v = 1'b1;
          store_v = 1'b1;
        end
      end
      POS_ADDR_HI: begin
        cur_a   = {held_q, b};
        begin_v = 1'b1;
      end
      POS_DATA_NONE, POS_DATA_SEEN: store_v = 1'b1;
    endcase
    if (begin_v) begin
      pos_a = POS_DATA_NONE;
    end
  end

  assign pb_a   = begin_v ? (cur_a & ~{8'd0, mask8}) : pb_q;
  assign bw_a   = begin_v ? 8'd0 : bw_q;
  assign stop_a = begin_v ? 1'b0 : stop_q;
  assign off    = cur_a[7:0] & mask8;

  // Page-wrapped store address, then the address after the store.
  assign eff       = pb_a + {8'd0, (off + bw_a) & mask8};
  assign can_store = store_v && !cfg_i.wr_lock && !stop_a;
  assign in_range  = eff < limit;
  assign do_wr     = can_store && in_range;
  assign bw_s      = bw_a + {7'd0, do_wr};
  assign stop_s    = stop_a || (can_store && !in_range);
  assign pos_s     = store_v ? POS_DATA_SEEN : pos_a;
  assign fin_addr  = pb_a + {8'd0, (off + bw_s) & mask8};

  always_comb begin
    pos_d       = pos_q;
    cur_d       = cur_q;
    busy_d      = busy_q;
    held_d      = held_q;
    pb_d        = pb_q;
    bw_d        = bw_q;
    stop_d      = stop_q;
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    ack_d       = ack_q;
    rvalid_d    = rvalid_q;
    bres_d      = bres_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = cur_q[AW-1:0];
    ram_wdata_o = b;

    if (clr_q) begin
      // Sweep the array to the erased value after reset.
      ram_we_o    = 1'b1;
      ram_addr_o  = clr_addr_q;
      ram_wdata_o = 8'hFF;
      clr_addr_d  = clr_addr_q + AW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end else if (accept) begin
      out_valid_d = 1'b1;
      ack_d       = 1'b0;
      rvalid_d    = 1'b0;
      unique case (in_data_i.func)
        FUNC_ADDR: begin
          ack_d  = cfg_i.device_enabled && (in_data_i.dev_addr == cfg_i.device_address)
                   && (busy_q == 16'd0);
          pos_d  = POS_IDLE;
          held_d = 8'd0;
          bw_d   = 8'd0;
          stop_d = 1'b0;
        end
        FUNC_WRITE: begin
          ram_we_o   = do_wr;
          ram_addr_o = eff[AW-1:0];
          pb_d       = pb_a;
          if (in_data_i.last_byte) begin
            if (!cfg_i.wr_lock && (pos_s == POS_DATA_NONE || pos_s == POS_DATA_SEEN)) begin
              cur_d = fin_addr;
              if (pos_s == POS_DATA_SEEN) begin
                busy_d = cfg_i.write_delay_ticks;
              end
            end else begin
              cur_d = cur_a;
            end
            pos_d  = POS_IDLE;
            held_d = 8'd0;
            bw_d   = 8'd0;
            stop_d = 1'b0;
          end else begin
            cur_d  = cur_a;
            pos_d  = pos_s;
            held_d = held_a;
            bw_d   = bw_s;
            stop_d = stop_s;
          end
        end
        FUNC_READ: begin
          if (cur_q < limit) begin
            ram_re_o = 1'b1;
            rvalid_d = 1'b1;
            cur_d    = cur_q + 16'd1;
          end
        end
        FUNC_TICK: begin
          if (busy_q != 16'd0) begin
            busy_d = busy_q - 16'd1;
          end
        end
      endcase
      bres_d = (busy_d != 16'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_IDLE;
      cur_q       <= '0;
      busy_q      <= '0;
      pb_q        <= '0;
      bw_q        <= '0;
      stop_q      <= 1'b0;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      cur_q       <= cur_d;
      busy_q      <= busy_d;
      pb_q        <= pb_d;
      bw_q        <= bw_d;
      stop_q      <= stop_d;
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Held byte and result fields carry no reset.
  always_ff @(posedge clk_i) begin
    held_q   <= held_d;
    ack_q    <= ack_d;
    rvalid_q <= rvalid_d;
    bres_q   <= bres_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ack_o        = ack_q;
  assign read_valid_o = rvalid_q;
  assign busy_res_o   = bres_q;

endmodule

@@ hdl/i2c_eeprom_target.sv @@
`timescale 1ns / 1ps
// Byte-event model of a serial EEPROM: one item in, one result out.
// Result registered, in the cycle after acceptance; one item per cycle while
// no sweep or stalled output holds the input, set by the single read or
// write port of the byte array. Reset: control state clears at once, then
// the array is swept to 0xFF, taking no item meanwhile; registers take writes.

`include "i2c_eeprom_target_defines.svh"

module i2c_eeprom_target
  import i2cee_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MemBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  item_t               in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output result_t             out_data_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  cfg_t          cfg;
  logic          ack, read_valid, busy_res, clearing;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  i2cee_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cee_core #(
    .MEM_BYTES (MEM_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ack_o        (ack),
    .read_valid_o (read_valid),
    .busy_res_o   (busy_res),
    .clearing_o   (clearing),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata)
  );

  i2cee_ram #(
    .Width (8),
    .Depth (MEM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Read data stays in the RAM output register until the next read.
  assign out_data_o.ack        = ack;
  assign out_data_o.read_data  = read_valid ? ram_rdata : 8'd0;
  assign out_data_o.read_valid = read_valid;
  assign out_data_o.busy_res   = busy_res;

  `I2CEE_ASSERT_NOW(a_clear_blocks_input, clearing, in_stall_o,
                    "item accepted during array sweep")
  `I2CEE_ASSERT_NOW(a_ack_not_busy, out_valid_o && out_data_o.ack,
                    !out_data_o.busy_res && !out_data_o.read_valid,
                    "acknowledged address phase reports busy or read data")
  `I2CEE_ASSERT_NEXT(a_addr_no_read,
                     in_valid_i && !in_stall_o && in_data_i.func == FUNC_ADDR,
                     out_valid_o && !out_data_o.read_valid && out_data_o.read_data == 8'd0,
                     "address phase produced read data")

endmodule
